/* rtl/core/dp2w_pkg.sv */
package dp2w_pkg;

	// depth pixel handling
	localparam logic [15:0] NAN_DEPTH = 16'd28672;   // 7 m in Q4.12
	localparam logic [15:0] MIN_DEPTH = 16'd205;     // first code at or above 0.05 m
	localparam logic [11:0] CX_TWICE  = 12'd641;
	localparam logic [11:0] CY_TWICE  = 12'd481;

	// back-projection: q = round(p * 80000 / 5542547), p = |2*col - 641| * depth
	localparam int unsigned PROD_W = 27;
	localparam int unsigned QUOT_W = 21;
	localparam int unsigned NUM_W  = 45;
	localparam logic [25:0] PROJ_RECIP = 26'((64'd80000 << 32) / 64'd5542547);
	localparam logic [17:0] PROJ_NUM2  = 18'd160000;
	localparam logic [23:0] PROJ_DEN   = 24'd5542547;
	localparam logic [25:0] PROJ_DEN2  = 26'd11085094;
	localparam logic [25:0] PROJ_DEN4  = 26'd22170188;
	localparam logic [25:0] PROJ_DEN6  = 26'd33255282;

	// camera y window, Q16.16
	localparam logic signed [21:0] Y_MAX = 22'sd6554;
	localparam logic signed [21:0] Y_MIN = -22'sd65536;

	typedef logic signed [21:0] cam_t;

	typedef struct packed {
		cam_t        x;
		cam_t        y;
		logic [19:0] z;
	} cam_pt_t;

	typedef struct packed {
		logic signed [17:0] wx_gain_x;
		logic signed [17:0] wx_gain_y;
		logic signed [17:0] wx_gain_z;
		logic signed [31:0] wx_offset;
		logic signed [17:0] wy_gain_x;
		logic signed [17:0] wy_gain_y;
		logic signed [17:0] wy_gain_z;
		logic signed [31:0] wy_offset;
	} pose_t;

	// register map, word index
	localparam logic [2:0] REG_WX_GAIN_X = 3'd0;
	localparam logic [2:0] REG_WX_GAIN_Y = 3'd1;
	localparam logic [2:0] REG_WX_GAIN_Z = 3'd2;
	localparam logic [2:0] REG_WX_OFFSET = 3'd3;
	localparam logic [2:0] REG_WY_GAIN_X = 3'd4;
	localparam logic [2:0] REG_WY_GAIN_Y = 3'd5;
	localparam logic [2:0] REG_WY_GAIN_Z = 3'd6;
	localparam logic [2:0] REG_WY_OFFSET = 3'd7;

	localparam logic signed [17:0] GAIN_ONE = 18'sd65536;

endpackage

/* rtl/core/dp2w_cfg.sv */
module dp2w_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output dp2w_pkg::pose_t      pose
);

	dp2w_pkg::pose_t pose_q;
	logic            wr_en;
	logic [2:0]      idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[4:2];
	assign pose   = pose_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_q.wx_gain_x <= dp2w_pkg::GAIN_ONE;
			pose_q.wx_gain_y <= '0;
			pose_q.wx_gain_z <= '0;
			pose_q.wx_offset <= '0;
			pose_q.wy_gain_x <= '0;
			pose_q.wy_gain_y <= dp2w_pkg::GAIN_ONE;
			pose_q.wy_gain_z <= '0;
			pose_q.wy_offset <= '0;
		end else if (wr_en) begin
			unique case (idx)
				dp2w_pkg::REG_WX_GAIN_X: pose_q.wx_gain_x <= pwdata[17:0];
				dp2w_pkg::REG_WX_GAIN_Y: pose_q.wx_gain_y <= pwdata[17:0];
				dp2w_pkg::REG_WX_GAIN_Z: pose_q.wx_gain_z <= pwdata[17:0];
				dp2w_pkg::REG_WX_OFFSET: pose_q.wx_offset <= pwdata;
				dp2w_pkg::REG_WY_GAIN_X: pose_q.wy_gain_x <= pwdata[17:0];
				dp2w_pkg::REG_WY_GAIN_Y: pose_q.wy_gain_y <= pwdata[17:0];
				dp2w_pkg::REG_WY_GAIN_Z: pose_q.wy_gain_z <= pwdata[17:0];
				dp2w_pkg::REG_WY_OFFSET: pose_q.wy_offset <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			dp2w_pkg::REG_WX_GAIN_X: prdata = 32'(pose_q.wx_gain_x);
			dp2w_pkg::REG_WX_GAIN_Y: prdata = 32'(pose_q.wx_gain_y);
			dp2w_pkg::REG_WX_GAIN_Z: prdata = 32'(pose_q.wx_gain_z);
			dp2w_pkg::REG_WX_OFFSET: prdata = pose_q.wx_offset;
			dp2w_pkg::REG_WY_GAIN_X: prdata = 32'(pose_q.wy_gain_x);
			dp2w_pkg::REG_WY_GAIN_Y: prdata = 32'(pose_q.wy_gain_y);
			dp2w_pkg::REG_WY_GAIN_Z: prdata = 32'(pose_q.wy_gain_z);
			dp2w_pkg::REG_WY_OFFSET: prdata = pose_q.wy_offset;
			default:                 prdata = '0;
		endcase
	end

endmodule

/* rtl/core/dp2w_proj.sv */
module dp2w_proj #(
	parameter int unsigned IMAGE_WIDTH  = 640,
	parameter int unsigned IMAGE_HEIGHT = 480
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       depth_value,
	input  logic              depth_is_nan,
	input  logic [9:0]        column,
	input  logic [9:0]        row,
	output logic              out_valid,
	input  logic              out_ready,
	output dp2w_pkg::cam_pt_t out_pt
);

	localparam int unsigned PW = dp2w_pkg::PROD_W;
	localparam int unsigned QW = dp2w_pkg::QUOT_W;
	localparam int unsigned NW = dp2w_pkg::NUM_W;

	// stage 1: depth select, pixel window, offset magnitude times depth
	logic [15:0]        depth_sel;
	logic [11:0]        off_c, off_r;
	logic [10:0]        mag_c, mag_r;
	logic               keep;
	logic [PW-1:0]      px_c, py_c;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic               rdy1, rdy2, rdy3, rdy4;

	logic [PW-1:0]      px_s1, py_s1;
	logic               negx_s1, negy_s1, negx_s2, negy_s2, negx_s3, negy_s3;
	logic [15:0]        depth_s1, depth_s2, depth_s3, depth_s4;

	logic [PW+25:0]     rx_c, ry_c;
	logic [QW-1:0]      qx0_s2, qy0_s2, qx0_s3, qy0_s3;
	logic [NW-1:0]      nx_s2, ny_s2, nx_s3, ny_s3, tx_s3, ty_s3;

	logic [NW-1:0]      rem_x, rem_y;
	logic [QW-1:0]      qx, qy;
	dp2w_pkg::cam_t     x_s4, y_s4;

	assign depth_sel = depth_is_nan ? dp2w_pkg::NAN_DEPTH : depth_value;
	assign off_c     = {1'b0, column, 1'b0} - dp2w_pkg::CX_TWICE;
	assign off_r     = {1'b0, row, 1'b0} - dp2w_pkg::CY_TWICE;
	assign mag_c     = off_c[11] ? 11'(-off_c) : off_c[10:0];
	assign mag_r     = off_r[11] ? 11'(-off_r) : off_r[10:0];
	assign keep      = ({1'b0, column} < 11'(IMAGE_WIDTH)) &&
	                   ({1'b0, row} < 11'(IMAGE_HEIGHT)) &&
	                   (depth_sel >= dp2w_pkg::MIN_DEPTH);
	assign px_c      = PW'(mag_c) * PW'(depth_sel);
	assign py_c      = PW'(mag_r) * PW'(depth_sel);

	// a stage takes a new item when empty or when its successor moves on
	assign rdy4     = !valid_s4 || out_ready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid && keep;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	// stage 2: quotient estimate by reciprocal, exact rounding numerator
	assign rx_c = (PW+26)'(px_s1) * (PW+26)'(dp2w_pkg::PROJ_RECIP);
	assign ry_c = (PW+26)'(py_s1) * (PW+26)'(dp2w_pkg::PROJ_RECIP);

	// stage 4: estimate is low by at most two; the remainder settles it
	assign rem_x = nx_s3 - tx_s3;
	assign rem_y = ny_s3 - ty_s3;
	assign qx    = qx0_s3 + QW'(rem_x >= NW'(dp2w_pkg::PROJ_DEN2))
	                      + QW'(rem_x >= NW'(dp2w_pkg::PROJ_DEN4));
	assign qy    = qy0_s3 + QW'(rem_y >= NW'(dp2w_pkg::PROJ_DEN2))
	                      + QW'(rem_y >= NW'(dp2w_pkg::PROJ_DEN4));

	always_ff @(posedge clk) begin
		if (rdy1) begin
			px_s1    <= px_c;
			py_s1    <= py_c;
			negx_s1  <= off_c[11];
			negy_s1  <= off_r[11];
			depth_s1 <= depth_sel;
		end
		if (rdy2) begin
			qx0_s2   <= rx_c[PW+25:32];
			qy0_s2   <= ry_c[PW+25:32];
			nx_s2    <= NW'(px_s1) * NW'(dp2w_pkg::PROJ_NUM2) + NW'(dp2w_pkg::PROJ_DEN);
			ny_s2    <= NW'(py_s1) * NW'(dp2w_pkg::PROJ_NUM2) + NW'(dp2w_pkg::PROJ_DEN);
			negx_s2  <= negx_s1;
			negy_s2  <= negy_s1;
			depth_s2 <= depth_s1;
		end
		if (rdy3) begin
			tx_s3    <= NW'(qx0_s2) * NW'(dp2w_pkg::PROJ_DEN2);
			ty_s3    <= NW'(qy0_s2) * NW'(dp2w_pkg::PROJ_DEN2);
			qx0_s3   <= qx0_s2;
			qy0_s3   <= qy0_s2;
			nx_s3    <= nx_s2;
			ny_s3    <= ny_s2;
			negx_s3  <= negx_s2;
			negy_s3  <= negy_s2;
			depth_s3 <= depth_s2;
		end
		if (rdy4) begin
			x_s4     <= negx_s3 ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
			y_s4     <= negy_s3 ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
			depth_s4 <= depth_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_pt.x  = x_s4;
	assign out_pt.y  = y_s4;
	assign out_pt.z  = {depth_s4, 4'b0000};

	// reciprocal error must leave the quotient within two of the truth
	a_rem_x_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rem_x < NW'(dp2w_pkg::PROJ_DEN6)))
		else $error("x remainder out of correction range");

	a_rem_y_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (rem_y < NW'(dp2w_pkg::PROJ_DEN6)))
		else $error("y remainder out of correction range");

	a_near_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (depth_s1 >= dp2w_pkg::MIN_DEPTH))
		else $error("too-near pixel entered the pipeline");

endmodule

/* rtl/core/dp2w_xform.sv */
module dp2w_xform (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dp2w_pkg::cam_pt_t in_pt,
	input  dp2w_pkg::pose_t   pose,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       world_x,
	output logic [31:0]       world_y
);

	function automatic logic [31:0] sat32(input logic signed [41:0] acc,
	                                      input logic signed [31:0] offset);
		logic signed [32:0] tot;
		tot = 33'($signed(acc[41:16])) + 33'(offset);
		if (tot[32] != tot[31])
			sat32 = tot[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			sat32 = tot[31:0];
	endfunction

	localparam logic signed [41:0] HALF_LSB = 42'sd32768;

	logic               keep;
	logic signed [20:0] z_s;
	logic               valid_s5, valid_s6, valid_s7;
	logic               rdy5, rdy6, rdy7;

	logic signed [39:0] pxx_s5, pxy_s5, pxz_s5, pyx_s5, pyy_s5, pyz_s5;
	logic signed [41:0] sum_x_s6, sum_y_s6;
	logic [31:0]        wx_s7, wy_s7;

	// drop points outside the camera y window
	assign keep = (in_pt.y <= dp2w_pkg::Y_MAX) && (in_pt.y >= dp2w_pkg::Y_MIN);
	assign z_s  = $signed({1'b0, in_pt.z});

	assign rdy7     = !valid_s7 || out_ready;
	assign rdy6     = !valid_s6 || rdy7;
	assign rdy5     = !valid_s5 || rdy6;
	assign in_ready = rdy5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (rdy5) valid_s5 <= in_valid && keep;
			if (rdy6) valid_s6 <= valid_s5;
			if (rdy7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			pxx_s5 <= 40'(pose.wx_gain_x) * 40'(in_pt.x);
			pxy_s5 <= 40'(pose.wx_gain_y) * 40'(in_pt.y);
			pxz_s5 <= 40'(pose.wx_gain_z) * 40'(z_s);
			pyx_s5 <= 40'(pose.wy_gain_x) * 40'(in_pt.x);
			pyy_s5 <= 40'(pose.wy_gain_y) * 40'(in_pt.y);
			pyz_s5 <= 40'(pose.wy_gain_z) * 40'(z_s);
		end
		if (rdy6) begin
			sum_x_s6 <= 42'(pxx_s5) + 42'(pxy_s5) + 42'(pxz_s5) + HALF_LSB;
			sum_y_s6 <= 42'(pyx_s5) + 42'(pyy_s5) + 42'(pyz_s5) + HALF_LSB;
		end
		if (rdy7) begin
			wx_s7 <= sat32(sum_x_s6, pose.wx_offset);
			wy_s7 <= sat32(sum_y_s6, pose.wy_offset);
		end
	end

	assign out_valid = valid_s7;
	assign world_x   = wx_s7;
	assign world_y   = wy_s7;

	// a blocked stage keeps its sum
	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s6 && !rdy6) |=> (valid_s6 && $stable(sum_x_s6) && $stable(sum_y_s6)))
		else $error("stalled sum changed");

endmodule

/* rtl/core/depth_pixel_to_world_point_core.sv */
// Depth pixel to world point.
// Input stream s_*: one depth pixel per item. s_tdata carries depth (Q4.12 m),
// column and row; s_tuser flags a NaN sample, which is taken as 7 m. Pixels
// outside the image, nearer than 0.05 m, or with camera y above 0.1 m or
// below -1 m produce no item on the output.
// Output stream m_*: world x and y in Q16.16 metres, saturated to 32 bits,
// after the pinhole back-projection and the two pose rows held in the APB
// registers. Registers are to be written only while the pipeline is empty;
// the user is bound to this, as the block itself does not enforce it.
// Throughput: one item per cycle while m_tready is high, through the
// seven stages (four of projection, three of pose transform), one item each.
// When m_tready is low the output register holds its item; earlier stages
// keep filling until every stage is full, and only then s_tready falls.
// Reset clears all stage valid bits and loads the identity pose; there is no
// clearing pass, so s_tready is high from the first cycle after reset.
module depth_pixel_to_world_point_core #(
	parameter int unsigned IMAGE_WIDTH  = 640,
	parameter int unsigned IMAGE_HEIGHT = 480
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // depth_value[15:0], column[25:16], row[35:26], zero[39:36]
	input  logic        s_tuser,   // depth_is_nan
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // world_x[31:0], world_y[63:32]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dp2w_pkg::pose_t   pose;
	dp2w_pkg::cam_pt_t cam_pt;
	logic              cam_valid, cam_ready;
	logic [31:0]       world_x, world_y;

	dp2w_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pose    (pose)
	);

	dp2w_proj #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_proj (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.depth_value  (s_tdata[15:0]),
		.depth_is_nan (s_tuser),
		.column       (s_tdata[25:16]),
		.row          (s_tdata[35:26]),
		.out_valid    (cam_valid),
		.out_ready    (cam_ready),
		.out_pt       (cam_pt)
	);

	dp2w_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cam_valid),
		.in_ready  (cam_ready),
		.in_pt     (cam_pt),
		.pose      (pose),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.world_x   (world_x),
		.world_y   (world_y)
	);

	assign m_tdata = {world_y, world_x};

	// an empty output register means every stage can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output");

endmodule

/* tb/tb_depth_pixel_to_world_point_core.sv */
module tb_depth_pixel_to_world_point_core;

	localparam int unsigned IMG_W = 640;
	localparam int unsigned IMG_H = 480;

	localparam longint DEPTH_NAN_Q12 = 28672;
	localparam longint DEPTH_MIN_Q12 = 205;
	localparam longint OPT_CX2       = 641;
	localparam longint OPT_CY2       = 481;
	localparam longint FOCAL_NUM     = 80000;
	localparam longint FOCAL_DEN     = 5542547;
	localparam longint CAM_Y_HI      = 6554;
	localparam longint CAM_Y_LO      = -65536;
	localparam longint Q16_MAX       = 64'sd2147483647;
	localparam longint Q16_MIN       = -64'sd2147483648;

	typedef struct {
		logic [15:0] depth;
		logic        is_nan;
		logic [9:0]  col;
		logic [9:0]  row;
	} pixel_t;

	typedef struct {
		logic signed [31:0] wx;
		logic signed [31:0] wy;
	} world_pt_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	wire         s_tready;
	logic [39:0] s_tdata = '0;   // depth_value[15:0], column[25:16], row[35:26], zero[39:36]
	logic        s_tuser = 1'b0; // depth_is_nan
	wire         m_tvalid;
	logic        m_tready = 1'b0;
	wire  [63:0] m_tdata;        // world_x[31:0], world_y[63:32]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	wire  [31:0] prdata;
	wire         pready;

	dp2w_pkg::pose_t pose_now;
	pixel_t    pixel_backlog[$];
	world_pt_t world_expected[$];
	pixel_t    cur_px;
	world_pt_t fire_pt;
	world_pt_t want;
	int        px_queued = 0;
	int        px_taken = 0;
	int        points_seen = 0;
	int        fail_count = 0;
	int        src_wait = 0;
	int        sink_wait = 0;
	int        hold_left = 0;
	int        hold_seen = 0;
	bit        sink_hold = 1'b0;
	bit        src_quiet = 1'b0;
	bit        sink_quiet = 1'b0;

	depth_pixel_to_world_point_core #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// camera coordinate in Q16.16, rounded to nearest, ties away from zero
	function automatic longint cam_coord(input longint twice_off, input longint d);
		longint mag;
		longint q;
		mag = (twice_off < 0) ? -twice_off : twice_off;
		q = (2 * mag * d * FOCAL_NUM + FOCAL_DEN) / (2 * FOCAL_DEN);
		return (twice_off < 0) ? -q : q;
	endfunction

	function automatic logic signed [31:0] pose_row_out(
		input logic signed [17:0] gx,
		input logic signed [17:0] gy,
		input logic signed [17:0] gz,
		input logic signed [31:0] off,
		input longint x,
		input longint y,
		input longint z
	);
		longint acc;
		longint r;
		acc = longint'(gx) * x + longint'(gy) * y + longint'(gz) * z;
		r = ((acc + 64'sd32768) >>> 16) + longint'(off);
		if (r > Q16_MAX)
			r = Q16_MAX;
		if (r < Q16_MIN)
			r = Q16_MIN;
		return r[31:0];
	endfunction

	function automatic logic backproject(input pixel_t p, output world_pt_t w);
		longint d;
		longint x;
		longint y;
		longint z;
		w.wx = '0;
		w.wy = '0;
		if (p.col >= IMG_W || p.row >= IMG_H)
			return 1'b0;
		d = p.is_nan ? DEPTH_NAN_Q12 : longint'(p.depth);
		if (d < DEPTH_MIN_Q12)
			return 1'b0;
		z = d * 16;
		x = cam_coord(2 * longint'(p.col) - OPT_CX2, d);
		y = cam_coord(2 * longint'(p.row) - OPT_CY2, d);
		if (y > CAM_Y_HI || y < CAM_Y_LO)
			return 1'b0;
		w.wx = pose_row_out(pose_now.wx_gain_x, pose_now.wx_gain_y, pose_now.wx_gain_z,
			pose_now.wx_offset, x, y, z);
		w.wy = pose_row_out(pose_now.wy_gain_x, pose_now.wy_gain_y, pose_now.wy_gain_z,
			pose_now.wy_offset, x, y, z);
		return 1'b1;
	endfunction

	// pixel source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			src_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (backproject(cur_px, fire_pt))
					world_expected.insert(world_expected.size(), fire_pt);
				px_taken++;
				src_wait = src_quiet ? 0 : $urandom_range(0, 5);
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered item
			end else if (src_wait > 0) begin
				src_wait--;
				s_tvalid <= 1'b0;
			end else if (pixel_backlog.size() > 0) begin
				cur_px = pixel_backlog.pop_front();
				s_tdata  <= {4'b0, cur_px.row, cur_px.col, cur_px.depth};
				s_tuser  <= cur_px.is_nan;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
			if ($urandom_range(0, 39) == 0)
				src_quiet = !src_quiet;
		end
	end

	// back off for a long stretch so the pipeline fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left = 0;
			hold_seen = 0;
			sink_hold <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				hold_seen++;
			if (hold_left > 0)
				hold_left--;
			else if (m_tvalid && m_tready && (hold_seen == 60 || hold_seen == 200))
				hold_left = 80;
			sink_hold <= (hold_left > 0);
		end
	end

	// world point sink and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (world_expected.size() == 0) begin
					$display("%0t unexpected world point: expected none, got x %0d y %0d",
						$time, $signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
					fail_count++;
				end else begin
					want = world_expected.pop_front();
					if (m_tdata[31:0] !== want.wx) begin
						$display("%0t world_x mismatch: expected %0d, got %0d",
							$time, want.wx, $signed(m_tdata[31:0]));
						fail_count++;
					end
					if (m_tdata[63:32] !== want.wy) begin
						$display("%0t world_y mismatch: expected %0d, got %0d",
							$time, want.wy, $signed(m_tdata[63:32]));
						fail_count++;
					end
				end
				points_seen++;
				sink_wait = sink_quiet ? 0 : $urandom_range(0, 5);
			end
			if (sink_hold) begin
				m_tready <= 1'b0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
			if ($urandom_range(0, 39) == 0)
				sink_quiet = !sink_quiet;
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic load_pose(input dp2w_pkg::pose_t p);
		apb_write(dp2w_pkg::REG_WX_GAIN_X, 32'(p.wx_gain_x));
		apb_write(dp2w_pkg::REG_WX_GAIN_Y, 32'(p.wx_gain_y));
		apb_write(dp2w_pkg::REG_WX_GAIN_Z, 32'(p.wx_gain_z));
		apb_write(dp2w_pkg::REG_WX_OFFSET, p.wx_offset);
		apb_write(dp2w_pkg::REG_WY_GAIN_X, 32'(p.wy_gain_x));
		apb_write(dp2w_pkg::REG_WY_GAIN_Y, 32'(p.wy_gain_y));
		apb_write(dp2w_pkg::REG_WY_GAIN_Z, 32'(p.wy_gain_z));
		apb_write(dp2w_pkg::REG_WY_OFFSET, p.wy_offset);
		pose_now = p;
	endtask

	function automatic dp2w_pkg::pose_t uniform_pose(input logic signed [17:0] g,
		input logic signed [31:0] off);
		dp2w_pkg::pose_t p;
		p.wx_gain_x = g;
		p.wx_gain_y = g;
		p.wx_gain_z = g;
		p.wx_offset = off;
		p.wy_gain_x = g;
		p.wy_gain_y = g;
		p.wy_gain_z = g;
		p.wy_offset = off;
		return p;
	endfunction

	function automatic dp2w_pkg::pose_t random_pose();
		dp2w_pkg::pose_t p;
		p.wx_gain_x = 18'($urandom);
		p.wx_gain_y = 18'($urandom);
		p.wx_gain_z = 18'($urandom);
		p.wx_offset = $urandom;
		p.wy_gain_x = 18'($urandom);
		p.wy_gain_y = 18'($urandom);
		p.wy_gain_z = 18'($urandom);
		p.wy_offset = $urandom;
		return p;
	endfunction

	task automatic queue_pixel(input logic [15:0] depth, input logic is_nan,
		input logic [9:0] col, input logic [9:0] row);
		pixel_t p;
		p.depth  = depth;
		p.is_nan = is_nan;
		p.col    = col;
		p.row    = row;
		pixel_backlog.insert(pixel_backlog.size(), p);
		px_queued++;
	endtask

	task automatic queue_random_pixels(input int n);
		pixel_t p;
		repeat (n) begin
			p.depth  = 16'($urandom);
			p.is_nan = ($urandom_range(0, 15) == 0);
			p.col    = 10'($urandom);
			p.row    = 10'($urandom);
			// mostly pixels inside the image at or past the near limit; some pick rows and depths that survive the y window
			if ($urandom_range(0, 9) < 7) begin
				p.col   = 10'($urandom_range(0, IMG_W - 1));
				p.depth = 16'($urandom_range(0, 1) ? $urandom_range(205, 8191)
					: $urandom_range(205, 65535));
				p.row   = 10'($urandom_range(0, 1) ? $urandom_range(150, 260)
					: $urandom_range(0, IMG_H - 1));
			end
			pixel_backlog.insert(pixel_backlog.size(), p);
			px_queued++;
		end
	endtask

	// wait until every item is taken and every point has arrived, then let dropped items clear
	task automatic wait_drained();
		while (px_taken != px_queued || world_expected.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		pose_now = uniform_pose(18'sd0, 32'sd0);
		pose_now.wx_gain_x = dp2w_pkg::GAIN_ONE;
		pose_now.wy_gain_y = dp2w_pkg::GAIN_ONE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// near limit, nan handling, image border and the camera y window
		queue_pixel(16'd0, 1'b0, 10'd320, 10'd240);
		queue_pixel(16'd204, 1'b0, 10'd320, 10'd240);
		queue_pixel(16'd205, 1'b0, 10'd320, 10'd240);
		queue_pixel(16'hffff, 1'b0, 10'd320, 10'd243);
		queue_pixel(16'hffff, 1'b0, 10'd320, 10'd244);
		queue_pixel(16'hffff, 1'b0, 10'd320, 10'd206);
		queue_pixel(16'hffff, 1'b0, 10'd320, 10'd205);
		queue_pixel(16'd0, 1'b1, 10'd0, 10'd240);
		queue_pixel(16'hffff, 1'b1, 10'd639, 10'd240);
		queue_pixel(16'd4096, 1'b0, 10'd640, 10'd240);
		queue_pixel(16'hffff, 1'b1, 10'd1023, 10'd1023);
		queue_pixel(16'd4096, 1'b0, 10'd100, 10'd480);
		queue_pixel(16'd205, 1'b0, 10'd0, 10'd479);
		queue_pixel(16'd4096, 1'b0, 10'd639, 10'd0);
		queue_pixel(16'hffff, 1'b0, 10'd0, 10'd0);
		queue_pixel(16'hffff, 1'b0, 10'd0, 10'd240);
		queue_pixel(16'h5555, 1'b0, 10'h2aa, 10'd200);
		queue_pixel(16'haaaa, 1'b1, 10'h155, 10'h155);
		wait_drained();

		load_pose(uniform_pose(18'sh1ffff, 32'sh7fffffff));
		queue_random_pixels(40);
		wait_drained();

		load_pose(uniform_pose(-18'sd131072, 32'sh80000000));
		queue_random_pixels(40);
		wait_drained();

		repeat (6) begin
			load_pose(random_pose());
			queue_random_pixels(110);
			wait_drained();
		end

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
